/* hw/rtl/dspm_pkg.sv */
// Shared types and constants of the shortest-path engine.
package dspm_pkg;

	localparam int DIST_BITS = 16;
	localparam int NCNT_BITS = 7;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;
	localparam logic [1:0] ACT_NOP   = 2'd3;

	typedef struct packed {
		logic [DIST_BITS-1:0] dval;
		logic                 reached;
		logic                 settled;
	} vstate_t;

	typedef struct packed {
		logic init;
		logic shift;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR2,
		ST_FETCH,
		ST_SWEEP,
		ST_RESULT
	} state_t;

endpackage

/* hw/rtl/dspm_ram.sv */
// Generic single-port RAM with registered read.
module dspm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* hw/rtl/dspm_cell.sv */
// One vertex cell of the rotating distance ring.
module dspm_cell
	import dspm_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  vstate_t    init_state,
	input  vstate_t    shift_in,
	output vstate_t    state_out
);

	vstate_t v_q;

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			v_q <= init_state;
		end else if (ctrl.shift) begin
			v_q <= shift_in;
		end
	end

	assign state_out = v_q;

endmodule

/* hw/rtl/dspm_relax.sv */
// Settle and relax step applied to the vertex leaving the ring tail.
module dspm_relax
	import dspm_pkg::*;
#(
	parameter int NW = 5,
	parameter int WB = 8
) (
	input  vstate_t                cur,
	input  logic [WB-1:0]          weight,
	input  logic [NW-1:0]          idx,
	input  logic [NCNT_BITS-1:0]   n,
	input  logic [NW-1:0]          best_idx,
	input  logic [DIST_BITS-1:0]   best_dist,
	output vstate_t                nxt,
	output logic                   cand
);

	logic                 in_range;
	logic [DIST_BITS:0]   sum;
	logic [DIST_BITS-1:0] sat;

	always_comb begin
		in_range = NCNT_BITS'(idx) < n;
		sum = {1'b0, best_dist} + (DIST_BITS+1)'(weight);
		sat = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
		nxt = cur;
		if (idx == best_idx) begin
			nxt.settled = 1'b1;
		end
		if (in_range && weight != '0 && !nxt.settled &&
		    (!nxt.reached || sat < nxt.dval)) begin
			nxt.dval = sat;
			nxt.reached = 1'b1;
		end
		cand = in_range && nxt.reached && !nxt.settled;
	end

endmodule

/* hw/rtl/dijkstra_shortest_path_matrix.sv */
// Top level: adjacency store, vertex ring and query sequencer.
//
//  channel | dir | handshake            | beat
//  s_*     | in  | s_tvalid / s_tready  | tuser action, tdata edge and query fields
//  m_*     | out | m_tvalid / m_tready  | tdata path_length, path_found, bad_request
//  cfg_*   | in  | cfg_valid / cfg_ready| cfg_data vertex_count
//
// Edge write: two RAM writes. Clear: every entry of the adjacency RAM is written, one entry
// a cycle through the single RAM port. Query: one round per settled vertex; each round
// is one RAM fetch plus one trip around the ring.
// After reset the same clearing pass runs before the first beat is taken.
// A finished result waits in the output register; the next beat is not taken until
// a pending result has moved there.
module dijkstra_shortest_path_matrix
	import dspm_pkg::*;
#(
	parameter int MAX_NODES   = 32,
	parameter int WEIGHT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [4:0] edge_from, [9:5] edge_to, [17:10] edge_weight,
	// [22:18] source_vertex, [27:23] target_vertex
	input  logic [31:0] s_tdata,
	// [1:0] action
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] path_length, [16] path_found, [17] bad_request
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);

	localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int AW = 2 * NW;
	localparam logic [NW-1:0] LAST_IDX = NW'(MAX_NODES - 1);

	logic [4:0]           edge_from, edge_to, source_vertex, target_vertex;
	logic [7:0]           edge_weight;
	logic [1:0]           action;

	assign action        = s_tuser;
	assign edge_from     = s_tdata[4:0];
	assign edge_to       = s_tdata[9:5];
	assign edge_weight   = s_tdata[17:10];
	assign source_vertex = s_tdata[22:18];
	assign target_vertex = s_tdata[27:23];

	state_t               state_q, state_d;
	logic [5:0]           vcount_q;
	logic [NCNT_BITS-1:0] n;
	logic [AW-1:0]        clr_q;
	logic [NW-1:0]        wa_q, wb_q, idx_q, best_q, nbest_q, dst_q, src_s;
	logic [WEIGHT_BITS-1:0] ww_q;
	logic [DIST_BITS-1:0] bd_q, nbd_q, res_len_q;
	logic                 nhave_q, res_found_q, bad_q;
	logic                 accept, wr_ok, q_ok, sweep_last, take, next_have, out_free;
	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [WEIGHT_BITS-1:0] ram_wdata, ram_rdata;
	cell_ctrl_t           cctrl;
	vstate_t              ring [MAX_NODES];
	vstate_t              init_v [MAX_NODES];
	vstate_t              tail_nxt;
	logic                 cand;
	logic                 res_ok;

	assign cfg_ready = 1'b1;
	assign n = (NCNT_BITS'(vcount_q) > NCNT_BITS'(MAX_NODES)) ?
		NCNT_BITS'(MAX_NODES) : NCNT_BITS'(vcount_q);
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign wr_ok = (edge_from != edge_to) && (NCNT_BITS'(edge_from) < n) &&
		(NCNT_BITS'(edge_to) < n);
	assign q_ok = (NCNT_BITS'(source_vertex) < n) && (NCNT_BITS'(target_vertex) < n);
	assign src_s = NW'(source_vertex);
	assign sweep_last = (idx_q == LAST_IDX);
	assign take = cand && (!nhave_q || tail_nxt.dval < nbd_q);
	assign next_have = nhave_q || cand;
	assign out_free = !m_tvalid || m_tready;
	assign res_ok = !bad_q && res_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 6'd32;
		end else if (cfg_valid && cfg_ready) begin
			vcount_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_addr = {best_q, idx_q + NW'(1)};
		ram_wdata = '0;
		cctrl = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ram_addr = {NW'(edge_from), NW'(edge_to)};
				ram_wdata = WEIGHT_BITS'(edge_weight);
				if (accept) begin
					priority case (action)
						ACT_CLEAR: state_d = ST_CLEAR;
						ACT_WRITE: begin
							if (wr_ok) begin
								ram_we = 1'b1;
								state_d = ST_WR2;
							end
						end
						ACT_QUERY: begin
							if (q_ok) begin
								cctrl.init = 1'b1;
								state_d = ST_FETCH;
							end else begin
								state_d = ST_RESULT;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_WR2: begin
				ram_we = 1'b1;
				ram_addr = {wb_q, wa_q};
				ram_wdata = ww_q;
				state_d = ST_IDLE;
			end
			ST_FETCH: begin
				ram_addr = {best_q, NW'(0)};
				state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				cctrl.shift = 1'b1;
				if (sweep_last) begin
					state_d = next_have ? ST_FETCH : ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			idx_q <= '0;
			nhave_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end else begin
				clr_q <= '0;
			end
			if (state_q == ST_FETCH) begin
				idx_q <= '0;
				nhave_q <= 1'b0;
			end else if (state_q == ST_SWEEP) begin
				idx_q <= idx_q + NW'(1);
				nhave_q <= next_have;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wa_q <= NW'(edge_from);
			wb_q <= NW'(edge_to);
			ww_q <= WEIGHT_BITS'(edge_weight);
			best_q <= src_s;
			bd_q <= '0;
			dst_q <= NW'(target_vertex);
			bad_q <= !q_ok;
		end
		if (state_q == ST_SWEEP) begin
			if (take) begin
				nbest_q <= idx_q;
				nbd_q <= tail_nxt.dval;
			end
			if (idx_q == dst_q) begin
				res_len_q <= tail_nxt.dval;
				res_found_q <= tail_nxt.reached;
			end
			if (sweep_last) begin
				best_q <= take ? idx_q : nbest_q;
				bd_q <= take ? tail_nxt.dval : nbd_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			m_tdata <= {6'd0, bad_q, res_ok, res_ok ? res_len_q : 16'd0};
		end
	end

	dspm_ram #(
		.WIDTH(WEIGHT_BITS),
		.DEPTH(1 << AW)
	) u_adj (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// cell j holds vertex MAX_NODES-1-j between sweeps; vertex 0 starts at the tail
	for (genvar j = 0; j < MAX_NODES; j++) begin : g_cell
		always_comb begin
			init_v[j] = '0;
			init_v[j].reached = (src_s == NW'(MAX_NODES - 1 - j));
		end
		dspm_cell u_cell (
			.clk       (clk),
			.ctrl      (cctrl),
			.init_state(init_v[j]),
			.shift_in  ((j == 0) ? tail_nxt : ring[(j == 0) ? 0 : j - 1]),
			.state_out (ring[j])
		);
	end

	dspm_relax #(
		.NW(NW),
		.WB(WEIGHT_BITS)
	) u_relax (
		.cur      (ring[MAX_NODES-1]),
		.weight   (ram_rdata),
		.idx      (idx_q),
		.n        (n),
		.best_idx (best_q),
		.best_dist(bd_q),
		.nxt      (tail_nxt),
		.cand     (cand)
	);

	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && sweep_last && !next_have) |=> state_q == ST_RESULT)
		else $error("search did not finish after a sweep with no candidate");

	a_bad_query: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_QUERY && !q_ok) |=> (state_q == ST_RESULT && bad_q))
		else $error("out-of-range query not flagged");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && out_free) |=> m_tvalid)
		else $error("result not presented");

	a_fetch_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (state_q == ST_SWEEP && idx_q == '0))
		else $error("sweep did not start at vertex zero");

endmodule

/* sim/dspm_checker.sv */
// Checker: watches the beats of the shortest-path engine, predicts and compares results.
`timescale 1ns / 100ps
module dspm_checker
	import dspm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [5:0]  cfg_data,
	output int          fail_count,
	output int          pending_count
);

	// packed from the top bit down: matches m_tdata[17:0]
	typedef struct packed {
		logic        bad;
		logic        found;
		logic [15:0] len;
	} path_res_t;

	logic [7:0] weight_mat [32][32];
	logic [5:0] vcount;
	path_res_t  path_q[$];

	function automatic path_res_t solve_path(int n, int src, int dst);
		int tdist[32];
		bit reached[32];
		bit settled[32];
		path_res_t r;
		int best, best_d, sum;
		bit have;
		for (int i = 0; i < 32; i++) begin
			tdist[i] = 0; reached[i] = 0; settled[i] = 0;
		end
		reached[src] = 1;
		for (int round = 0; round < n; round++) begin
			have = 0; best = 0; best_d = 0;
			for (int i = 0; i < n; i++)
				if (reached[i] && !settled[i] && (!have || tdist[i] < best_d)) begin
					have = 1; best = i; best_d = tdist[i];
				end
			if (!have) break;
			settled[best] = 1;
			for (int i = 0; i < n; i++) begin
				if (weight_mat[best][i] == 0 || settled[i]) continue;
				sum = best_d + weight_mat[best][i];
				if (sum > 65535) sum = 65535;
				if (!reached[i] || sum < tdist[i]) begin
					tdist[i] = sum; reached[i] = 1;
				end
			end
		end
		r.bad = 0;
		r.found = reached[dst];
		r.len = reached[dst] ? tdist[dst][15:0] : 16'd0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int n, a, b, src, dst;
		int errs;
		path_res_t r, got;
		if (!arst_n) begin
			vcount <= 6'd32;
			fail_count <= 0;
			pending_count <= 0;
			for (int i = 0; i < 32; i++)
				for (int j = 0; j < 32; j++) weight_mat[i][j] = '0;
			path_q.delete();
		end else begin
			errs = 0;
			if (m_tvalid && m_tready) begin
				got = m_tdata[17:0];
				if (path_q.size() == 0) begin
					$error("unexpected result beat %h", m_tdata);
					errs++;
				end else begin
					r = path_q.pop_front();
					if (got.len !== r.len) begin
						$error("path_length expected %0d actual %0d", r.len, got.len);
						errs++;
					end
					if (got.found !== r.found) begin
						$error("path_found expected %0d actual %0d", r.found, got.found);
						errs++;
					end
					if (got.bad !== r.bad) begin
						$error("bad_request expected %0d actual %0d", r.bad, got.bad);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				n = (vcount > 32) ? 32 : vcount;
				a = s_tdata[4:0]; b = s_tdata[9:5];
				src = s_tdata[22:18]; dst = s_tdata[27:23];
				case (s_tuser)
					ACT_CLEAR: begin
						for (int i = 0; i < 32; i++)
							for (int j = 0; j < 32; j++) weight_mat[i][j] = '0;
					end
					ACT_WRITE: begin
						if (a != b && a < n && b < n) begin
							weight_mat[a][b] = s_tdata[17:10];
							weight_mat[b][a] = s_tdata[17:10];
						end
					end
					ACT_QUERY: begin
						if (src >= n || dst >= n) begin
							r.len = 0; r.found = 0; r.bad = 1;
						end else
							r = solve_path(n, src, dst);
						path_q.push_back(r);
					end
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready) vcount <= cfg_data;
			fail_count <= fail_count + errs;
			pending_count <= path_q.size();
		end
	end

endmodule

/* sim/tb.sv */
// Testbench top: stimulus, configuration phases and verdict for the shortest-path engine.
`timescale 1ns / 100ps
module tb;
	import dspm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;
	int          fail_count;
	int          pending_count;
	int          cycle_count;
	bit          calm;
	bit          hold_long;

	localparam int CYCLE_LIMIT = 3000000;

	dijkstra_shortest_path_matrix #(.MAX_NODES(32), .WEIGHT_BITS(8)) dut (.*);
	dspm_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		s_tvalid = 0; s_tdata = '0; s_tuser = '0;
		cfg_valid = 0; cfg_data = '0; m_tready = 0;
		calm = 0; hold_long = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end
	initial cycle_count = 0;

	// result side: random stall bursts, one long hold-off on request
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				m_tready <= 0;
				repeat (6000) @(posedge clk);
				hold_long = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 0;
				k = $urandom_range(1, 11);
				repeat (k) @(posedge clk);
			end else begin
				m_tready <= 1;
				@(posedge clk);
			end
		end
	end

	// tvalid stays high after the beat; drain() drops it, and the next call may drop it for a random gap
	task automatic send_beat(input logic [1:0] act, input logic [31:0] data);
		int k;
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			k = $urandom_range(1, 11);
			repeat (k) @(posedge clk);
		end
		s_tvalid <= 1; s_tuser <= act; s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [31:0] pack_item(int a, int b, int w, int src, int dst);
		return {4'(0), 5'(dst), 5'(src), 8'(w), 5'(b), 5'(a)};
	endfunction

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (4200) @(posedge clk);
	endtask

	task automatic set_count(input logic [5:0] v);
		drain();
		cfg_valid <= 1; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	// mostly random edge writes and queries among the first n vertices; occasional noise
	task automatic random_phase(input int items, input int n);
		int r, a, b, w;
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			a = (n > 0 && r < 80) ? $urandom_range(0, n - 1) : $urandom_range(0, 31);
			b = (n > 0 && r < 80) ? $urandom_range(0, n - 1) : $urandom_range(0, 31);
			w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255);
			if (r < 2) send_beat(ACT_CLEAR, $urandom);
			else if (r < 4) send_beat(ACT_NOP, $urandom);
			else if (r < 60) send_beat(ACT_WRITE, pack_item(a, b, w, $urandom, $urandom));
			else send_beat(ACT_QUERY, pack_item($urandom, $urandom, $urandom, a, b));
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		// directed: default count of 32
		send_beat(ACT_QUERY, pack_item(0, 0, 0, 0, 0));
		send_beat(ACT_QUERY, pack_item(0, 0, 0, 0, 31));
		send_beat(ACT_WRITE, pack_item(0, 31, 255, 0, 0));
		send_beat(ACT_WRITE, pack_item(5, 5, 9, 0, 0));
		send_beat(ACT_WRITE, pack_item(0, 1, 1, 0, 0));
		send_beat(ACT_WRITE, pack_item(1, 31, 3, 0, 0));
		send_beat(ACT_QUERY, pack_item(0, 0, 0, 0, 31));
		send_beat(ACT_QUERY, pack_item(0, 0, 0, 5, 5));
		send_beat(ACT_QUERY, pack_item(0, 0, 0, 5, 0));
		send_beat(ACT_WRITE, pack_item(1, 31, 0, 0, 0));
		send_beat(ACT_QUERY, pack_item(0, 0, 0, 31, 0));
		send_beat(ACT_NOP, 32'hFFFF_FFFF);
		send_beat(ACT_CLEAR, 32'hFFFF_FFFF);
		send_beat(ACT_QUERY, pack_item(0, 0, 0, 0, 31));
		send_beat(ACT_WRITE, pack_item(2, 3, 7, 31, 31));
		// back pressure: long receiver hold-off while queries pile up
		hold_long = 1;
		for (int i = 0; i < 6; i++) send_beat(ACT_QUERY, pack_item(0, 0, 0, 2, 3));
		drain();
		set_count(6'd0);
		send_beat(ACT_WRITE, pack_item(0, 1, 4, 0, 0));
		send_beat(ACT_QUERY, pack_item(0, 0, 0, 0, 0));
		set_count(6'd63);
		send_beat(ACT_QUERY, pack_item(0, 0, 0, 2, 3));
		set_count(6'd4);
		send_beat(ACT_QUERY, pack_item(0, 0, 0, 0, 31));
		send_beat(ACT_WRITE, pack_item(3, 10, 5, 0, 0));
		set_count(6'd1);
		send_beat(ACT_QUERY, pack_item(0, 0, 0, 0, 0));
		set_count(6'd2);
		random_phase(40, 2);
		set_count(6'd5);
		random_phase(120, 5);
		set_count(6'd8);
		random_phase(150, 8);
		set_count(6'd3);
		random_phase(100, 3);
		set_count(6'd32);
		random_phase(80, 32);
		set_count(6'd6);
		calm = 1;
		random_phase(90, 6);
		drain();
		if (fail_count == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
